>>> rtl/core/pfa_pkg.sv
// Package for the page frame allocator core: commands, status codes, FSM
// state and the controller/datapath handshake structs. No dependencies.
package pfa_pkg;

    localparam int PAGES_DEF         = 65536;
    localparam int MAP_WORD_BITS_DEF = 32;

    localparam logic [15:0] REF_MAX = 16'hFFFF;
    localparam logic [16:0] CNT_MAX = 17'h1FFFF;

    localparam int IN_DATA_W  = 56;  // command, page, last_page, limit_page
    localparam int OUT_DATA_W = 56;  // status, alloc_page, ref_count, used_count

    typedef enum logic [2:0] {
        CMD_ALLOC       = 3'd0,
        CMD_ALLOC_BELOW = 3'd1,
        CMD_RELEASE     = 3'd2,
        CMD_REF_INC     = 3'd3,
        CMD_REF_QUERY   = 3'd4,
        CMD_RESERVE     = 3'd5,
        CMD_FREE        = 3'd6,
        CMD_UNKNOWN     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_READ,
        S_EVAL,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic prep;
        logic rd;
        logic eval;
        logic emit;
    } ctl_t;

    typedef struct packed {
        logic clr_done;
        logic prep_fin;
        logic eval_fin;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/page_frame_allocator_refcount_core.sv
// Page frame allocator with reference counts: one result beat per command.
// Each command is decoded first; release, increment and query then read and
// evaluate one bitmap word, while ranges and allocations read and evaluate one
// word at a time (one read port); unknown, out-of-range and zero-bound allocs skip this.
// No new command is taken before the last result reaches the output register, where it waits.
// After reset a clearing pass over all PAGES pages (65536 by default) sets the
// bitmap to all-used and the counts to zero; configuration is taken meanwhile.
module page_frame_allocator_refcount_core #(
    parameter int PAGES         = pfa_pkg::PAGES_DEF,
    parameter int MAP_WORD_BITS = pfa_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command[2:0], page[18:3], last_page[34:19], limit_page[51:35], zero pad
    input  logic [pfa_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], alloc_page[17:2], ref_count[33:18], used_count[50:34], zero pad
    output logic [pfa_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [16:0]                    cfg_data
);

    pfa_pkg::ctl_t ctl;
    pfa_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    pfa_datapath #(
        .PAGES         (PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

>>> rtl/core/pfa_ctrl.sv
// Sequencing FSM for the allocator: clearing pass, item intake, word
// read/evaluate loop and result hand-off. Depends on pfa_pkg.
module pfa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pfa_pkg::sts_t sts,
    output pfa_pkg::ctl_t ctl
);

    pfa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfa_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pfa_pkg::S_CLEAR: begin
                ctl.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = pfa_pkg::S_PREP;
                end
            end
            pfa_pkg::S_PREP: begin
                ctl.prep   = 1'b1;
                state_next = sts.prep_fin ? pfa_pkg::S_RESULT : pfa_pkg::S_READ;
            end
            pfa_pkg::S_READ: begin
                ctl.rd     = 1'b1;
                state_next = pfa_pkg::S_EVAL;
            end
            pfa_pkg::S_EVAL: begin
                ctl.eval   = 1'b1;
                state_next = sts.eval_fin ? pfa_pkg::S_RESULT : pfa_pkg::S_READ;
            end
            pfa_pkg::S_RESULT: begin
                if (sts.out_free) begin
                    ctl.emit   = 1'b1;
                    state_next = pfa_pkg::S_IDLE;
                end
            end
            default: state_next = pfa_pkg::S_CLEAR;
        endcase
    end

endmodule

>>> rtl/core/pfa_datapath.sv
// Allocator datapath: bitmap and refcount memories, scan window, counters,
// configuration register and output register. Depends on pfa_pkg.
module pfa_datapath #(
    parameter int PAGES         = pfa_pkg::PAGES_DEF,
    parameter int MAP_WORD_BITS = pfa_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pfa_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          cfg_valid,
    input  logic [16:0]                   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfa_pkg::OUT_DATA_W-1:0] m_tdata,
    input  pfa_pkg::ctl_t                 ctl,
    output pfa_pkg::sts_t                 sts
);

    // word size must be a power of two
    localparam int W         = MAP_WORD_BITS;
    localparam int WB        = $clog2(W);
    localparam int MAP_WORDS = (PAGES + W - 1) / W;
    localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PW        = $clog2(PAGES);
    localparam int CW        = PW + 1;
    localparam int EW        = (CW > 17) ? CW : 17;
    localparam int AW        = WIW + WB;

    logic [W-1:0]  map_mem [MAP_WORDS];
    logic [15:0]   ref_mem [PAGES];
    logic [W-1:0]  map_q_reg;
    logic [15:0]   ref_q_reg;

    pfa_pkg::cmd_t cmd_reg;
    logic [15:0]   in_page_reg, in_last_reg;
    logic [16:0]   in_limit_reg;
    logic [CW-1:0] total_reg, hint_reg, page_reg, lo_reg, hi_reg, start_reg;
    logic [16:0]   cnt_reg;
    logic [WIW-1:0] word_reg;
    logic          phase_reg, bad_reg;
    logic [CW-1:0] clr_reg;

    logic [1:0]    res_status_reg;
    logic [15:0]   res_alloc_reg, res_ref_reg;
    logic          m_valid_reg;
    logic [pfa_pkg::OUT_DATA_W-1:0] m_data_reg;

    // ---- prep decode
    logic [EW-1:0] page_e, total_e, last_e, limit_e, hint_e, bound_e, start_e, end_e, lo_e, hi_e;
    logic          in_range, prep_fin;
    logic [1:0]    prep_status;

    always_comb begin
        page_e      = EW'(in_page_reg);
        last_e      = EW'(in_last_reg);
        limit_e     = EW'(in_limit_reg);
        total_e     = EW'(total_reg);
        hint_e      = EW'(hint_reg);
        in_range    = page_e < total_e;
        bound_e     = (cmd_reg == pfa_pkg::CMD_ALLOC_BELOW && limit_e < total_e) ? limit_e
                                                                                 : total_e;
        start_e     = (hint_e >= bound_e) ? '0 : hint_e;
        end_e       = (last_e >= total_e) ? total_e - 1'b1 : last_e;
        prep_fin    = 1'b0;
        prep_status = pfa_pkg::ST_IGNORED;
        lo_e        = page_e;
        hi_e        = page_e + 1'b1;
        case (cmd_reg)
            pfa_pkg::CMD_ALLOC, pfa_pkg::CMD_ALLOC_BELOW: begin
                lo_e = start_e;
                hi_e = bound_e;
                if (bound_e == '0) begin
                    prep_fin    = 1'b1;
                    prep_status = pfa_pkg::ST_NO_FREE;
                end
            end
            pfa_pkg::CMD_RESERVE, pfa_pkg::CMD_FREE: begin
                prep_fin = !in_range;
                if (last_e >= page_e) begin
                    hi_e = end_e + 1'b1;
                end
            end
            pfa_pkg::CMD_RELEASE, pfa_pkg::CMD_REF_INC, pfa_pkg::CMD_REF_QUERY: begin
                prep_fin = !in_range;
            end
            default: prep_fin = 1'b1;
        endcase
    end

    // ---- word window mask
    logic [CW-1:0] hi_m1;
    logic [WB-1:0] lo_off, hi_off;
    logic          at_lo, at_hi;
    logic [W-1:0]  mask, free_bits, hit_bits;
    logic [WB-1:0] free_idx;
    logic          free_any;
    logic [AW-1:0] found_p;
    logic [WB:0]   n_bits;

    always_comb begin
        hi_m1  = hi_reg - 1'b1;
        lo_off = lo_reg[WB-1:0];
        hi_off = hi_m1[WB-1:0];
        at_lo  = WIW'(lo_reg >> WB) == word_reg;
        at_hi  = WIW'(hi_m1 >> WB) == word_reg;
        mask   = ({W{1'b1}} << (at_lo ? lo_off : '0)) &
                 ({W{1'b1}} >> (at_hi ? ~hi_off : '0));
        free_bits = ~map_q_reg & mask;
        free_any  = |free_bits;
        free_idx  = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = WB'(i);
            end
        end
        found_p  = {word_reg, free_idx};
        hit_bits = (cmd_reg == pfa_pkg::CMD_RESERVE) ? free_bits : (map_q_reg & mask);
        n_bits   = (WB + 1)'($countones(hit_bits));
    end

    // ---- evaluate
    logic          bit_used, eval_fin;
    logic          map_we, ref_we;
    logic [WIW-1:0] map_wa;
    logic [W-1:0]  map_wd;
    logic [PW-1:0] ref_wa;
    logic [15:0]   ref_wd, ref_new;
    logic          cnt_up, cnt_down_one, cnt_add, cnt_sub;
    logic [17:0]   cnt_sum;
    logic [16:0]   cnt_n;

    always_comb begin
        bit_used     = map_q_reg[page_reg[WB-1:0]];
        eval_fin     = 1'b1;
        map_we       = 1'b0;
        ref_we       = 1'b0;
        map_wa       = word_reg;
        map_wd       = map_q_reg;
        ref_wa       = PW'(page_reg);
        ref_wd       = '0;
        ref_new      = ref_q_reg;
        cnt_up       = 1'b0;
        cnt_down_one = 1'b0;
        cnt_add      = 1'b0;
        cnt_sub      = 1'b0;
        case (cmd_reg)
            pfa_pkg::CMD_ALLOC, pfa_pkg::CMD_ALLOC_BELOW: begin
                if (free_any) begin
                    map_we = 1'b1;
                    map_wd = map_q_reg | (W'(1) << free_idx);
                    ref_we = 1'b1;
                    ref_wa = PW'(found_p);
                    ref_wd = 16'd1;
                    cnt_up = 1'b1;
                end else if (!at_hi || (!phase_reg && start_reg != '0)) begin
                    eval_fin = 1'b0;
                end
            end
            pfa_pkg::CMD_RELEASE: begin
                if (bit_used) begin
                    if (ref_q_reg > 16'd1) begin
                        ref_new = ref_q_reg - 1'b1;
                    end else if (ref_q_reg == 16'd1) begin
                        ref_new      = '0;
                        map_we       = 1'b1;
                        map_wd       = map_q_reg & ~(W'(1) << page_reg[WB-1:0]);
                        cnt_down_one = 1'b1;
                    end
                    ref_we = 1'b1;
                    ref_wd = ref_new;
                end
            end
            pfa_pkg::CMD_REF_INC: begin
                if (bit_used) begin
                    if (ref_q_reg != pfa_pkg::REF_MAX) begin
                        ref_new = ref_q_reg + 1'b1;
                    end
                    ref_we = 1'b1;
                    ref_wd = ref_new;
                end
            end
            pfa_pkg::CMD_RESERVE, pfa_pkg::CMD_FREE: begin
                if (!bad_reg) begin
                    map_we   = 1'b1;
                    map_wd   = (cmd_reg == pfa_pkg::CMD_RESERVE) ? (map_q_reg | mask)
                                                                 : (map_q_reg & ~mask);
                    cnt_add  = cmd_reg == pfa_pkg::CMD_RESERVE;
                    cnt_sub  = cmd_reg == pfa_pkg::CMD_FREE;
                    eval_fin = at_hi;
                end
            end
            default: ;
        endcase
        if (ctl.clr_step) begin
            map_we = 1'b1;
            map_wa = WIW'(clr_reg >> WB);
            map_wd = '1;
            ref_we = 1'b1;
            ref_wa = PW'(clr_reg);
            ref_wd = '0;
        end else if (!ctl.eval) begin
            map_we = 1'b0;
            ref_we = 1'b0;
        end
        cnt_n   = (cnt_up || cnt_down_one) ? 17'd1 : 17'(n_bits);
        cnt_sum = 18'(cnt_reg) + 18'(cnt_n);
    end

    // ---- memories
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (ctl.rd) begin
            map_q_reg <= map_mem[word_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (ref_we) begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (ctl.rd) begin
            ref_q_reg <= ref_mem[PW'(page_reg)];
        end
    end

    // ---- control registers
    logic [EW-1:0] cfg_e;
    always_comb begin
        cfg_e = EW'(cfg_data);
        if (cfg_e == '0 || cfg_e > EW'(PAGES)) begin
            cfg_e = EW'(PAGES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= CW'(PAGES);
            cnt_reg     <= 17'(PAGES);
            hint_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.clr_step) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid) begin
                total_reg <= CW'(cfg_e);
                cnt_reg   <= 17'(cfg_e);
            end else if (ctl.eval) begin
                if (cnt_up || cnt_add) begin
                    cnt_reg <= (cnt_sum > 18'(pfa_pkg::CNT_MAX)) ? pfa_pkg::CNT_MAX
                                                                 : cnt_sum[16:0];
                end else if (cnt_down_one || cnt_sub) begin
                    cnt_reg <= (cnt_reg < cnt_n) ? '0 : cnt_reg - cnt_n;
                end
            end
            if (ctl.eval && cnt_up) begin
                hint_reg <= CW'(found_p) + 1'b1;
            end else if (ctl.eval && cnt_down_one && page_reg < hint_reg) begin
                hint_reg <= page_reg;
            end
            if (ctl.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---- item and scan registers
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg      <= pfa_pkg::cmd_t'(s_tdata[2:0]);
            in_page_reg  <= s_tdata[18:3];
            in_last_reg  <= s_tdata[34:19];
            in_limit_reg <= s_tdata[51:35];
        end
        if (ctl.prep) begin
            page_reg       <= CW'(page_e);
            lo_reg         <= CW'(lo_e);
            hi_reg         <= CW'(hi_e);
            start_reg      <= CW'(start_e);
            word_reg       <= WIW'(lo_e >> WB);
            phase_reg      <= 1'b0;
            bad_reg        <= last_e < page_e;
            res_status_reg <= prep_status;
            res_alloc_reg  <= '0;
            res_ref_reg    <= '0;
        end
        if (ctl.eval) begin
            res_alloc_reg <= '0;
            res_ref_reg   <= ref_q_reg;
            case (cmd_reg)
                pfa_pkg::CMD_ALLOC, pfa_pkg::CMD_ALLOC_BELOW: begin
                    res_ref_reg <= '0;
                    if (free_any) begin
                        res_status_reg <= pfa_pkg::ST_DONE;
                        res_alloc_reg  <= 16'(found_p);
                        res_ref_reg    <= 16'd1;
                    end else if (!at_hi) begin
                        word_reg <= word_reg + 1'b1;
                    end else if (!phase_reg && start_reg != '0) begin
                        // wrap: pages below the start point
                        phase_reg <= 1'b1;
                        lo_reg    <= '0;
                        hi_reg    <= start_reg;
                        word_reg  <= '0;
                    end else begin
                        res_status_reg <= pfa_pkg::ST_NO_FREE;
                    end
                end
                pfa_pkg::CMD_RELEASE, pfa_pkg::CMD_REF_INC: begin
                    res_status_reg <= bit_used ? pfa_pkg::ST_DONE : pfa_pkg::ST_IGNORED;
                    res_ref_reg    <= ref_new;
                end
                pfa_pkg::CMD_REF_QUERY: begin
                    res_status_reg <= pfa_pkg::ST_DONE;
                end
                default: begin
                    res_status_reg <= bad_reg ? pfa_pkg::ST_IGNORED : pfa_pkg::ST_DONE;
                    if (!at_hi) begin
                        word_reg <= word_reg + 1'b1;
                    end
                end
            endcase
        end
        if (ctl.emit) begin
            m_data_reg <= {5'd0, cnt_reg, res_ref_reg, res_alloc_reg, res_status_reg};
        end
    end

    assign sts.clr_done = clr_reg == CW'(PAGES - 1);
    assign sts.prep_fin = prep_fin;
    assign sts.eval_fin = eval_fin;
    assign sts.out_free = !m_valid_reg || m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;

endmodule

>>> rtl/core/pfa_checker.sv
// Port-level checks for the allocator core, bound to the top level.
// Depends on pfa_pkg.
module pfa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pfa_pkg::OUT_DATA_W-1:0] m_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result beat dropped");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("stalled beat changed");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second command taken while busy");

    a_alloc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != pfa_pkg::ST_DONE |-> m_tdata[17:2] == 16'd0)
        else $error("page handed out on a failed command");

    a_nofree_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == pfa_pkg::ST_NO_FREE |-> m_tdata[33:18] == 16'd0)
        else $error("count reported on failed allocation");

endmodule

bind page_frame_allocator_refcount_core pfa_checker u_pfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for page_frame_allocator_refcount_core: directed table,
// a run of increments on one page and random phases; results are checked against
// table values or an in-bench predictor. Depends on pfa_pkg and the core RTL only.
module tb_top;

    localparam int NPAGES   = pfa_pkg::PAGES_DEF;
    localparam int WDOG_MAX = 300000;

    typedef struct {
        pfa_pkg::status_t st;
        logic [15:0]      ap;
        logic [15:0]      rc;
        logic [16:0]      uc;
    } res_t;

    typedef struct {
        pfa_pkg::cmd_t c;
        int            pg;
        int            lp;
        int            lim;
        bit            chk;
        res_t          r;
    } row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pfa_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pfa_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [16:0]                    cfg_data = '0;

    // predictor state
    bit          pm_used [NPAGES];
    logic [15:0] pm_refs [NPAGES];
    int          pm_total;
    int          pm_used_cnt;
    int          pm_hint;

    res_t   pending_results [$];
    row_t   dir_rows [$];
    int     n_mismatch = 0;
    int     n_items = 0;
    int     n_results = 0;
    int     n_alloc_ok = 0;
    int     n_no_free = 0;
    int     n_ignored = 0;
    int     n_cfg = 0;
    int     wdog = 0;
    bit     idle_en = 1'b1;
    bit     hold_req = 1'b0;

    always #10 aclk = ~aclk;

    page_frame_allocator_refcount_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // command, page, last_page, limit_page, pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // status, alloc_page, ref_count, used_count, pad
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic void alloc_reset();
        for (int i = 0; i < NPAGES; i++) begin
            pm_used[i] = 1'b1;
            pm_refs[i] = '0;
        end
        pm_total = NPAGES;
        pm_used_cnt = NPAGES;
        pm_hint = 0;
    endfunction

    function automatic void alloc_set_total(int v);
        v = v & 17'h1FFFF;
        if (v == 0 || v > NPAGES) v = NPAGES;
        pm_total = v;
        pm_used_cnt = v;
    endfunction

    function automatic void cnt_up();
        if (pm_used_cnt < pfa_pkg::CNT_MAX) pm_used_cnt++;
    endfunction

    function automatic void cnt_down();
        if (pm_used_cnt > 0) pm_used_cnt--;
    endfunction

    function automatic res_t alloc_apply(pfa_pkg::cmd_t c, int pg, int lp, int lim);
        res_t r;
        int   bound;
        int   start;
        int   found;
        int   p;
        int   last_p;
        bit   in_rng;
        r.st = pfa_pkg::ST_IGNORED;
        r.ap = '0;
        r.rc = '0;
        in_rng = pg < pm_total;
        case (c)
            pfa_pkg::CMD_ALLOC, pfa_pkg::CMD_ALLOC_BELOW: begin
                bound = pm_total;
                if (c == pfa_pkg::CMD_ALLOC_BELOW && lim < bound) bound = lim;
                start = (pm_hint >= bound) ? 0 : pm_hint;
                found = bound;
                for (int i = 0; i < bound; i++) begin
                    p = start + i;
                    if (p >= bound) p -= bound;
                    if (!pm_used[p]) begin
                        found = p;
                        break;
                    end
                end
                if (found < bound) begin
                    pm_used[found] = 1'b1;
                    cnt_up();
                    pm_refs[found] = 16'd1;
                    pm_hint = found + 1;
                    r.st = pfa_pkg::ST_DONE;
                    r.ap = found[15:0];
                    r.rc = 16'd1;
                end else begin
                    r.st = pfa_pkg::ST_NO_FREE;
                end
            end
            pfa_pkg::CMD_RELEASE, pfa_pkg::CMD_REF_INC: begin
                if (in_rng) begin
                    if (!pm_used[pg]) begin
                        r.st = pfa_pkg::ST_IGNORED;
                    end else if (c == pfa_pkg::CMD_RELEASE) begin
                        r.st = pfa_pkg::ST_DONE;
                        if (pm_refs[pg] > 1) begin
                            pm_refs[pg]--;
                        end else if (pm_refs[pg] == 1) begin
                            pm_refs[pg] = '0;
                            pm_used[pg] = 1'b0;
                            cnt_down();
                            if (pg < pm_hint) pm_hint = pg;
                        end
                    end else begin
                        r.st = pfa_pkg::ST_DONE;
                        if (pm_refs[pg] != pfa_pkg::REF_MAX) pm_refs[pg]++;
                    end
                    r.rc = pm_refs[pg];
                end
            end
            pfa_pkg::CMD_REF_QUERY: begin
                if (in_rng) begin
                    r.st = pfa_pkg::ST_DONE;
                    r.rc = pm_refs[pg];
                end
            end
            pfa_pkg::CMD_RESERVE, pfa_pkg::CMD_FREE: begin
                if (in_rng && lp >= pg) begin
                    last_p = (lp >= pm_total) ? pm_total - 1 : lp;
                    for (int q = pg; q <= last_p; q++) begin
                        if (c == pfa_pkg::CMD_RESERVE && !pm_used[q]) begin
                            pm_used[q] = 1'b1;
                            cnt_up();
                        end else if (c == pfa_pkg::CMD_FREE && pm_used[q]) begin
                            pm_used[q] = 1'b0;
                            cnt_down();
                        end
                    end
                    r.st = pfa_pkg::ST_DONE;
                end
                if (in_rng) r.rc = pm_refs[pg];
            end
            default: ;
        endcase
        r.uc = pm_used_cnt[16:0];
        return r;
    endfunction

    // one command beat; a random idle burst may come first when enabled
    task automatic send_cmd(pfa_pkg::cmd_t c, int pg, int lp, int lim, bit chk, res_t typed);
        res_t r;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, lim[16:0], lp[15:0], pg[15:0], c};
        do @(posedge aclk); while (!s_tready);
        r = alloc_apply(c, pg, lp, lim);
        pending_results.push_back(chk ? typed : r);
        n_items++;
        @(negedge aclk);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_total(int v);
        go_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v[16:0];
        do @(posedge aclk); while (!cfg_ready);
        alloc_set_total(v);
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(pfa_pkg::cmd_t c, int pg, int lp, int lim, bit chk,
                                    pfa_pkg::status_t st, int ap, int rc, int uc);
        row_t w;
        w.c = c; w.pg = pg; w.lp = lp; w.lim = lim; w.chk = chk;
        w.r.st = st; w.r.ap = ap[15:0]; w.r.rc = rc[15:0]; w.r.uc = uc[16:0];
        dir_rows.push_back(w);
    endfunction

    // window keeps pages colliding so allocs, releases and ranges interact
    task automatic run_random(int n_cmds, int win);
        int            k;
        int            pg;
        int            lp;
        int            lim;
        pfa_pkg::cmd_t c;
        res_t          none;
        none = '{pfa_pkg::ST_DONE, '0, '0, '0};
        send_cmd(pfa_pkg::CMD_FREE, 0, win - 1, 0, 1'b0, none);
        for (int i = 0; i < n_cmds; i++) begin
            k = $urandom_range(0, 99);
            if (k < 25)      c = pfa_pkg::CMD_ALLOC;
            else if (k < 35) c = pfa_pkg::CMD_ALLOC_BELOW;
            else if (k < 55) c = pfa_pkg::CMD_RELEASE;
            else if (k < 70) c = pfa_pkg::CMD_REF_INC;
            else if (k < 80) c = pfa_pkg::CMD_REF_QUERY;
            else if (k < 87) c = pfa_pkg::CMD_RESERVE;
            else if (k < 97) c = pfa_pkg::CMD_FREE;
            else             c = pfa_pkg::CMD_UNKNOWN;
            if ($urandom_range(0, 9) == 0) pg = $urandom_range(0, 65535);
            else                           pg = $urandom_range(0, win - 1);
            if ($urandom_range(0, 9) == 0) lp = $urandom_range(0, 65535);
            else                           lp = pg + $urandom_range(0, 16) - 2;
            if (lp < 0) lp = 0;
            if (lp > 65535) lp = 65535;
            if ($urandom_range(0, 7) == 0) lim = $urandom_range(0, 131071);
            else                           lim = $urandom_range(0, win + 4);
            if (i == n_cmds / 3 && idle_en) hold_req = 1'b1;
            send_cmd(c, pg, lp, lim, 1'b0, none);
        end
    endtask

    // receiver: random stall bursts plus one long hold on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (m_tvalid && m_tready) begin
            got.st = pfa_pkg::status_t'(m_tdata[1:0]);
            got.ap = m_tdata[17:2];
            got.rc = m_tdata[33:18];
            got.uc = m_tdata[50:34];
            n_results++;
            if (got.st == pfa_pkg::ST_DONE && got.ap != 0) n_alloc_ok++;
            if (got.st == pfa_pkg::ST_NO_FREE) n_no_free++;
            if (got.st == pfa_pkg::ST_IGNORED) n_ignored++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result beat: %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.st !== want.st || got.ap !== want.ap || got.rc !== want.rc ||
                    got.uc !== want.uc || m_tdata[55:51] !== 5'b0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result %0d: exp st=%0d ap=%0d rc=%0d uc=%0d, got st=%0d ap=%0d rc=%0d uc=%0d",
                                 n_results, want.st, want.ap, want.rc, want.uc,
                                 got.st, got.ap, got.rc, got.uc);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog > WDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        res_t none;
        none = '{pfa_pkg::ST_DONE, '0, '0, '0};
        alloc_reset();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table from the reset state: all pages used, counts zero
        add_row(pfa_pkg::CMD_REF_QUERY,   0,     0,     0,      1, pfa_pkg::ST_DONE,    0, 0, 65536);
        add_row(pfa_pkg::CMD_REF_QUERY,   65535, 0,     0,      1, pfa_pkg::ST_DONE,    0, 0, 65536);
        add_row(pfa_pkg::CMD_ALLOC,       0,     0,     0,      1, pfa_pkg::ST_NO_FREE, 0, 0, 65536);
        add_row(pfa_pkg::CMD_RELEASE,     5,     0,     0,      1, pfa_pkg::ST_DONE,    0, 0, 65536);
        add_row(pfa_pkg::CMD_REF_INC,     65535, 0,     0,      1, pfa_pkg::ST_DONE,    0, 1, 65536);
        add_row(pfa_pkg::CMD_ALLOC_BELOW, 0,     0,     0,      1, pfa_pkg::ST_NO_FREE, 0, 0, 65536);
        add_row(pfa_pkg::CMD_FREE,        0,     31,    0,      1, pfa_pkg::ST_DONE,    0, 0, 65504);
        add_row(pfa_pkg::CMD_FREE,        10,    5,     0,      1, pfa_pkg::ST_IGNORED, 0, 0, 65504);
        add_row(pfa_pkg::CMD_UNKNOWN,     0,     0,     0,      1, pfa_pkg::ST_IGNORED, 0, 0, 65504);
        add_row(pfa_pkg::CMD_RELEASE,     3,     0,     0,      1, pfa_pkg::ST_IGNORED, 0, 0, 65504);
        add_row(pfa_pkg::CMD_REF_INC,     4,     0,     0,      1, pfa_pkg::ST_IGNORED, 0, 0, 65504);
        add_row(pfa_pkg::CMD_ALLOC,       0,     0,     0,      1, pfa_pkg::ST_DONE,    0, 1, 65505);
        add_row(pfa_pkg::CMD_ALLOC_BELOW, 0,     0,     131071, 0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_REF_INC,     0,     0,     0,      0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_RELEASE,     0,     0,     0,      0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_RELEASE,     0,     0,     0,      0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_ALLOC_BELOW, 0,     0,     1,      0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_ALLOC,       0,     0,     0,      0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_RESERVE,     0,     65535, 0,      0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_FREE,        65500, 65535, 0,      0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_ALLOC_BELOW, 0,     0,     65510,  0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_ALLOC,       0,     0,     0,      0, pfa_pkg::ST_DONE,    0, 0, 0);
        add_row(pfa_pkg::CMD_RESERVE,     65530, 40000, 0,      0, pfa_pkg::ST_DONE,    0, 0, 0);
        foreach (dir_rows[i])
            send_cmd(dir_rows[i].c, dir_rows[i].pg, dir_rows[i].lp, dir_rows[i].lim,
                     dir_rows[i].chk, dir_rows[i].r);

        // send increments to one page back to back, then a release; the page is free here, so all are ignored
        idle_en = 1'b0;
        for (int i = 0; i < 60; i++) send_cmd(pfa_pkg::CMD_REF_INC, 65535, 0, 0, 1'b0, none);
        send_cmd(pfa_pkg::CMD_RELEASE, 65535, 0, 0, 1'b0, none);
        idle_en = 1'b1;

        write_total(1);      run_random(120, 1);
        write_total(0);      run_random(80, 256);
        write_total(64);     run_random(200, 64);
        write_total(131071); run_random(60, 512);
        write_total(33);     run_random(200, 33);
        write_total(200);    run_random(250, 200);
        idle_en = 1'b0;
        write_total(65536);  run_random(150, 128);

        go_idle();
        repeat (200) @(negedge aclk);
        $display("%0d commands, %0d result beats, %0d register writes (1 to 65536 pages)",
                 n_items, n_results, n_cfg);
        $display("%0d nonzero allocs, %0d no-free, %0d ignored; %0d mismatches",
                 n_alloc_ok, n_no_free, n_ignored, n_mismatch);
        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/core/pfa_pkg.sv
rtl/core/pfa_ctrl.sv
rtl/core/pfa_datapath.sv
rtl/core/page_frame_allocator_refcount_core.sv
rtl/core/pfa_checker.sv
tb/sv/tb_top.sv
